### hdl/sobel_pkg.sv
// Shared constants, register codes and the per-channel gradient function for the Sobel filter.
`default_nettype none

package sobel_pkg;

  localparam int unsigned MAX_WIDTH    = 2048;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;
  localparam int unsigned MIN_SIZE     = 3;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 3 * CHAN_W;
  localparam int unsigned CCOL_W  = 11;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned CFG_WIDTH_W = 12;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // |Gv| + |Gh| for one channel, saturated to 8 bits.
  // pRC: R = 0 top .. 2 bottom, C = 0 left .. 2 right; the centre has weight zero.
  function automatic logic [CHAN_W-1:0] sobel_mag(
    input logic [CHAN_W-1:0] p00, input logic [CHAN_W-1:0] p01,
    input logic [CHAN_W-1:0] p02, input logic [CHAN_W-1:0] p10,
    input logic [CHAN_W-1:0] p12, input logic [CHAN_W-1:0] p20,
    input logic [CHAN_W-1:0] p21, input logic [CHAN_W-1:0] p22
  );
    logic [9:0]         top_sum, bot_sum, lft_sum, rgt_sum;
    logic signed [10:0] gv, gh;
    logic [9:0]         gv_abs, gh_abs;
    logic [10:0]        mag;
    top_sum = 10'(p00) + {1'b0, p01, 1'b0} + 10'(p02);
    bot_sum = 10'(p20) + {1'b0, p21, 1'b0} + 10'(p22);
    lft_sum = 10'(p00) + {1'b0, p10, 1'b0} + 10'(p20);
    rgt_sum = 10'(p02) + {1'b0, p12, 1'b0} + 10'(p22);
    gv = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
    gh = $signed({1'b0, lft_sum}) - $signed({1'b0, rgt_sum});
    gv_abs = gv[10] ? 10'(-gv) : gv[9:0];
    gh_abs = gh[10] ? 10'(-gh) : gh[9:0];
    mag = 11'(gv_abs) + 11'(gh_abs);
    return (mag > 11'd255) ? 8'hFF : mag[7:0];
  endfunction

endpackage

`default_nettype wire

### hdl/sobel_if.sv
// Channel interfaces of the Sobel filter: pixel input, edge result and register write.
`default_nettype none

interface sobel_pix_if;
  logic                         valid;
  logic                         ready;
  logic [sobel_pkg::CHAN_W-1:0] pixel_red;
  logic [sobel_pkg::CHAN_W-1:0] pixel_green;
  logic [sobel_pkg::CHAN_W-1:0] pixel_blue;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface sobel_edge_if;
  logic                         valid;
  logic                         ready;
  logic [sobel_pkg::CHAN_W-1:0] edge_red;
  logic [sobel_pkg::CHAN_W-1:0] edge_green;
  logic [sobel_pkg::CHAN_W-1:0] edge_blue;
  logic [sobel_pkg::CCOL_W-1:0] centre_column;
  logic [sobel_pkg::ROW_W-1:0]  centre_row;
  logic                         frame_last;

  modport source (output valid, edge_red, edge_green, edge_blue, centre_column, centre_row,
                  frame_last, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, centre_column, centre_row,
                  frame_last, output ready);
endinterface

interface sobel_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sobel_pkg::CFG_IDX_W-1:0]  index;
  logic [sobel_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/sobel_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sobel_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/rgb_sobel_edge_filter_top.sv
// Top level of the 3x3 Sobel edge filter on a raster stream of RGB pixels.
// Channels: pix_i takes one RGB pixel per beat in raster order, edge_o gives one
// edge beat per interior pixel (border pixels give none), cfg_i writes
// image_width (index 0) and image_height (index 1) while the block is idle; the
// user is bound to this, as the block does not enforce it. Widths are clamped to
// 3..MAX_WIDTH and heights raised to at least 3 on write. Throughput: one pixel
// per cycle while edge_o does not stall, set by the single read port and single
// write port of each line store (one read and one write-back per pixel). The
// accepting edge registers the pixel into the read stage along with the line-store
// reads; when the read stage moves on, the filter loads the output register that
// drives edge_o. The result for centre (c, r) comes with pixel (c + 1, r + 1).
// Reset clears the column and row counters, the window and the pipeline
// valids, and loads 640 x 480; the line stores hold stale data, which is
// never used inside a frame of constant width.
// A stall on edge_o holds the output register; pixels that give no result
// still pass, but once a pixel that gives a result reaches the read stage,
// pix_i.ready drops until the held result is taken.
`default_nettype none

module rgb_sobel_edge_filter_top #(
  parameter int unsigned MAX_WIDTH = sobel_pkg::MAX_WIDTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sobel_pix_if.sink     pix_i,
  sobel_cfg_if.sink     cfg_i,
  sobel_edge_if.source  edge_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WEW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW  = sobel_pkg::PIXEL_W;
  localparam int unsigned RW  = sobel_pkg::ROW_W;
  localparam int unsigned CCW = sobel_pkg::CCOL_W;
  localparam int unsigned CHW = sobel_pkg::CHAN_W;
  localparam int unsigned WIDTH_RST =
    (sobel_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : sobel_pkg::WIDTH_RESET;

  // ---------------- configuration ----------------
  logic [WEW-1:0] width_q;
  logic [RW-1:0]  height_q;
  logic [sobel_pkg::CFG_WIDTH_W-1:0] cfg_width_raw;
  logic [RW-1:0]  cfg_height_raw;
  logic           cfg_fire;

  assign cfg_i.ready    = 1'b1;
  assign cfg_fire       = cfg_i.valid && cfg_i.ready;
  assign cfg_width_raw  = cfg_i.data[sobel_pkg::CFG_WIDTH_W-1:0];
  assign cfg_height_raw = cfg_i.data[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WEW'(WIDTH_RST);
      height_q <= RW'(sobel_pkg::HEIGHT_RESET);
    end else if (cfg_fire) begin
      unique case (sobel_pkg::cfg_reg_e'(cfg_i.index))
        sobel_pkg::CFG_IMAGE_WIDTH: begin
          if (32'(cfg_width_raw) < sobel_pkg::MIN_SIZE) begin
            width_q <= WEW'(sobel_pkg::MIN_SIZE);
          end else if (32'(cfg_width_raw) > MAX_WIDTH) begin
            width_q <= WEW'(MAX_WIDTH);
          end else begin
            width_q <= WEW'(cfg_width_raw);
          end
        end
        sobel_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= (32'(cfg_height_raw) < sobel_pkg::MIN_SIZE) ?
                      RW'(sobel_pkg::MIN_SIZE) : cfg_height_raw;
        end
        default: ;
      endcase
    end
  end

  // ---------------- accept stage: counters and line-store read ----------------
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           in_fire;
  logic           col_wrap, row_wrap;
  logic           res_a, last_a;
  logic [CCW-1:0] ccol_a;
  logic [RW-1:0]  crow_a;
  logic [PW-1:0]  pix_a;

  logic           s1_valid_q, s1_res_q, s1_last_q, s1_go;
  logic [CW-1:0]  s1_addr_q;
  logic [PW-1:0]  s1_pix_q;
  logic [CCW-1:0] s1_ccol_q;
  logic [RW-1:0]  s1_crow_q;

  logic           out_valid_q;

  assign s1_go       = s1_valid_q && (!s1_res_q || !out_valid_q || edge_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_go;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign pix_a       = {pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue};

  assign col_wrap = (32'(col_q) + 32'd1) >= 32'(width_q);
  assign row_wrap = (32'(row_q) + 32'd1) >= 32'(height_q);
  assign res_a    = (32'(col_q) >= 32'd2) && (32'(row_q) >= 32'd2) &&
                    (32'(col_q) < 32'(width_q)) && (row_q < height_q);
  assign last_a   = (32'(col_q) == 32'(width_q) - 32'd1) &&
                    (32'(row_q) == 32'(height_q) - 32'd1);
  assign ccol_a   = CCW'(col_q - CW'(1));
  assign crow_a   = row_q - RW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_res_q  <= res_a;
      s1_last_q <= last_a;
      s1_addr_q <= col_q;
      s1_pix_q  <= pix_a;
      s1_ccol_q <= ccol_a;
      s1_crow_q <= crow_a;
    end
  end

  // ---------------- line stores ----------------
  logic [PW-1:0] up_rd, mid_rd;

  sobel_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_rd),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  sobel_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // ---------------- window and filter stage ----------------
  // slots 0..2: column c-2, slots 3..5: column c-1, rows upper, middle, current
  logic [PW-1:0]  win_q [6];
  logic [CHW-1:0] mag [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_go) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up_rd;
      win_q[4] <= mid_rd;
      win_q[5] <= s1_pix_q;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mag[ch] = sobel_pkg::sobel_mag(
        win_q[0][(2-ch)*CHW +: CHW], win_q[3][(2-ch)*CHW +: CHW], up_rd[(2-ch)*CHW +: CHW],
        win_q[1][(2-ch)*CHW +: CHW], mid_rd[(2-ch)*CHW +: CHW],
        win_q[2][(2-ch)*CHW +: CHW], win_q[5][(2-ch)*CHW +: CHW],
        s1_pix_q[(2-ch)*CHW +: CHW]);
    end
  end

  // ---------------- output register ----------------
  logic [CHW-1:0] edge_red_q, edge_green_q, edge_blue_q;
  logic [CCW-1:0] ccol_q;
  logic [RW-1:0]  crow_q;
  logic           last_q;
  logic           out_load;

  assign out_load = s1_go && s1_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (edge_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      edge_red_q   <= mag[0];
      edge_green_q <= mag[1];
      edge_blue_q  <= mag[2];
      ccol_q       <= s1_ccol_q;
      crow_q       <= s1_crow_q;
      last_q       <= s1_last_q;
    end
  end

  assign edge_o.valid         = out_valid_q;
  assign edge_o.edge_red      = edge_red_q;
  assign edge_o.edge_green    = edge_green_q;
  assign edge_o.edge_blue     = edge_blue_q;
  assign edge_o.centre_column = ccol_q;
  assign edge_o.centre_row    = crow_q;
  assign edge_o.frame_last    = last_q;

`ifndef SYNTHESIS
  // a pending result is never overwritten by the filter stage
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !edge_o.ready |-> !out_load)
    else $error("output register overwritten while stalled");

  // a held read stage blocks new pixels, so the line-store read data stays put
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |-> !pix_i.ready)
    else $error("pixel accepted while read stage is held");

  // back-to-back pixels never touch the same line-store entry, so no bypass is needed
  a_no_addr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s1_go |-> col_q != s1_addr_q)
    else $error("read and write-back hit the same line-store entry");

  // the last result of a frame sits one column left of the right border
  a_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> 32'(ccol_q) == 32'(width_q) - 32'd2)
    else $error("frame_last on a column other than the last interior one");
`endif

endmodule

`default_nettype wire

### tb/sobel_tb_pkg.sv
// Scoreboard for the Sobel filter testbench: edge prediction and result checking.
`default_nettype none

package sobel_tb_pkg;
  import sobel_pkg::*;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CCOL_W-1:0] column;
    logic [ROW_W-1:0]  row;
    logic              last;
  } edge_beat_t;

  class sobel_edge_scoreboard;
    int unsigned width_reg;
    int unsigned height_reg;
    pixel_t      upper_line [MAX_WIDTH];
    pixel_t      middle_line [MAX_WIDTH];
    // slots 0..2: column c-2, slots 3..5: column c-1 (upper, middle, current row)
    pixel_t      window_cols [6];
    pixel_t      nbhd [3][3];
    int unsigned col_cnt;
    int unsigned row_cnt;
    edge_beat_t  pending_edges [$];
    int          errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window_cols[i]) window_cols[i] = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_IMAGE_WIDTH) begin
        width_reg = value[CFG_WIDTH_W-1:0];
      end else begin
        height_reg = value;
      end
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_SIZE) return MIN_SIZE;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    function bit at_frame_start();
      return (col_cnt == 0) && (row_cnt == 0);
    endfunction

    function int unsigned pending();
      return pending_edges.size();
    endfunction

    // |Gv| + |Gh| of one channel of the current neighbourhood, saturated
    function logic [CHAN_W-1:0] channel_mag(int unsigned sh);
      int p [3][3];
      int gv;
      int gh;
      int s;
      foreach (p[i, j]) p[i][j] = int'(nbhd[i][j][sh +: CHAN_W]);
      gv = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
      gh = (p[0][0] + 2 * p[1][0] + p[2][0]) - (p[0][2] + 2 * p[1][2] + p[2][2]);
      s  = (gv < 0 ? -gv : gv) + (gh < 0 ? -gh : gh);
      return (s > 255) ? 8'hFF : 8'(s);
    endfunction

    function void note_pixel(pixel_t px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned slot;
      int          k;
      pixel_t      up;
      pixel_t      mid;
      edge_beat_t  e;
      w    = eff_width();
      h    = eff_height();
      c    = col_cnt;
      r    = row_cnt;
      slot = c % MAX_WIDTH;
      up   = upper_line[slot];
      mid  = middle_line[slot];
      if (c >= 2 && r >= 2 && c < w && r < h) begin
        for (k = 0; k < 3; k++) begin
          nbhd[k][0] = window_cols[k];
          nbhd[k][1] = window_cols[3 + k];
        end
        nbhd[0][2] = up;
        nbhd[1][2] = mid;
        nbhd[2][2] = px;
        e.red    = channel_mag(16);
        e.green  = channel_mag(8);
        e.blue   = channel_mag(0);
        e.column = CCOL_W'(c - 1);
        e.row    = ROW_W'(r - 1);
        e.last   = (c == w - 1) && (r == h - 1);
        pending_edges.push_back(e);
      end
      upper_line[slot]  = mid;
      middle_line[slot] = px;
      for (k = 0; k < 3; k++) window_cols[k] = window_cols[3 + k];
      window_cols[3] = up;
      window_cols[4] = mid;
      window_cols[5] = px;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want,
                       edge_beat_t want_beat);
      if (got !== want) begin
        report($sformatf("%s at centre (%0d,%0d): got %0d, want %0d", name,
                         want_beat.column, want_beat.row, got, want));
      end
    endtask

    task check_edge(edge_beat_t got);
      edge_beat_t want;
      if (pending_edges.size() == 0) begin
        report($sformatf("edge beat at centre (%0d,%0d) with nothing pending",
                         got.column, got.row));
        return;
      end
      want = pending_edges.pop_front();
      compare_field("edge_red", got.red, want.red, want);
      compare_field("edge_green", got.green, want.green, want);
      compare_field("edge_blue", got.blue, want.blue, want);
      compare_field("centre_column", got.column, want.column, want);
      compare_field("centre_row", got.row, want.row, want);
      compare_field("frame_last", got.last, want.last, want);
    endtask
  endclass

endpackage

`default_nettype wire

### tb/tb_rgb_sobel_edge_filter_top.sv
// Testbench top: drives pixel, register and edge channels and checks every edge beat.
`default_nettype none

module tb_rgb_sobel_edge_filter_top;
  import sobel_pkg::*;
  import sobel_tb_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned RANDOM_ITEMS = 300;

  logic clk_i;
  logic rst_ni;
  bit   no_gaps;
  int   idle_cycles = 0;

  sobel_edge_scoreboard sb;

  sobel_pix_if  pix_if ();
  sobel_cfg_if  cfg_if ();
  sobel_edge_if edge_if ();

  rgb_sobel_edge_filter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .edge_o (edge_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Restart the count on any accepted beat; give up after a long quiet stretch.
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_rgb_sobel_edge_filter_top: errors");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_red   <= px[23:16];
    pix_if.pixel_green <= px[15:8];
    pix_if.pixel_blue  <= px[7:0];
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    sb.note_pixel(px);
  endtask

  // Drop valid and hold until every pending edge beat is out.
  task automatic hold_until_drained(input int unsigned extra);
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic run_pixels(input int unsigned count);
    repeat (count) begin
      send_pixel(pixel_t'($urandom));
      if ($urandom_range(0, 199) == 0) hold_until_drained(0);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Height first; finish the running frame before the width changes.
  task automatic set_size(input logic [CFG_DATA_W-1:0] wdata,
                          input logic [CFG_DATA_W-1:0] hdata);
    hold_until_drained(DRAIN_CYCLES);
    write_reg(CFG_IMAGE_HEIGHT, hdata);
    if (!sb.at_frame_start()) begin
      while (!sb.at_frame_start()) send_pixel(pixel_t'($urandom));
      hold_until_drained(DRAIN_CYCLES);
    end
    write_reg(CFG_IMAGE_WIDTH, wdata);
  endtask

  // 3x3 frames: top row bright, flat black, and mixed per-channel edges.
  function automatic pixel_t directed_pixel(int unsigned frame, int unsigned pos);
    int unsigned row;
    int unsigned col;
    row = pos / 3;
    col = pos % 3;
    case (frame)
      0: return (row == 0) ? 24'hFFFFFF : 24'h000000;
      1: return 24'h000000;
      default: begin
        return {(col == 0) ? 8'hFF : 8'h00, (row == 0) ? 8'hFF : 8'h00, 8'(row * 3 + col)};
      end
    endcase
  endfunction

  initial begin : edge_sink
    int unsigned stall;
    edge_beat_t  beat;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        edge_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      edge_if.ready <= 1'b1;
      do @(posedge clk_i); while (edge_if.valid !== 1'b1);
      beat.red    = edge_if.edge_red;
      beat.green  = edge_if.edge_green;
      beat.blue   = edge_if.edge_blue;
      beat.column = edge_if.centre_column;
      beat.row    = edge_if.centre_row;
      beat.last   = edge_if.frame_last;
      sb.check_edge(beat);
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned pick;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    int unsigned count;
    sb = new();
    random_items       = 0;
    no_gaps            = 1'b0;
    rst_ni             <= 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_red   <= '0;
    pix_if.pixel_green <= '0;
    pix_if.pixel_blue  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_IMAGE_WIDTH;
    cfg_if.data        <= '0;
    edge_if.ready      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size: two rows and a bit at the default width.
    run_pixels(2 * WIDTH_RESET + 8);

    set_size(16'd3, 16'd3);
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 9; i++) send_pixel(directed_pixel(f, i));
    end

    // Upper data bits fall outside the width register; height below range rises to three.
    set_size(16'hF005, 16'd0);
    run_pixels(2 * sb.frame_pixels());

    // Tallest frame, cut short by the next height write.
    set_size(16'd3, 16'hFFFF);
    run_pixels(3 * 40);

    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        wdata = CFG_DATA_W'($urandom_range(0, 2));
      end else if (pick == 1) begin
        wdata = CFG_DATA_W'(($urandom_range(0, 15) << CFG_WIDTH_W) | $urandom_range(3, 12));
      end else begin
        wdata = CFG_DATA_W'($urandom_range(3, 12));
      end
      hdata = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                          : CFG_DATA_W'($urandom_range(3, 6));
      set_size(wdata, hdata);
      no_gaps = ($urandom_range(0, 3) == 0);
      count   = $urandom_range(1, 3) * sb.frame_pixels();
      run_pixels(count);
      random_items += count;
    end

    no_gaps = 1'b0;
    hold_until_drained(DRAIN_CYCLES);
    if (sb.errors == 0) begin
      $display("tb_rgb_sobel_edge_filter_top: clean");
    end else begin
      $display("tb_rgb_sobel_edge_filter_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
